@@ sv/autoranging_force_percent_tracker_assert.svh @@
// Assertion macros for the force percent tracker.
// Clocked on clk_i and disabled while rst_ni is low.
`ifndef AUTORANGING_FORCE_PERCENT_TRACKER_ASSERT_SVH
`define AUTORANGING_FORCE_PERCENT_TRACKER_ASSERT_SVH

// same-cycle implication
`define AFTRK_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define AFTRK_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/aftrk_pkg.sv @@
// Shared types and constants of the force percent tracker.
// No dependencies.
package aftrk_pkg;

  localparam int SampleW = 32;
  localparam int SpeedW  = 16;
  localparam int ChanW   = 4;
  localparam int PctW    = 8;
  localparam int QuoW    = 7;
  localparam int NumW    = 38;
  localparam int BitW    = 3;
  localparam int PctScale = 100;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_MUL,
    ST_DIV,
    ST_PWR,
    ST_SCAN,
    ST_DONE
  } state_e;

endpackage

@@ sv/aftrk_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module aftrk_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/autoranging_force_percent_tracker.sv @@
// Top level of the autoranging force percent tracker.
// Uses aftrk_pkg, aftrk_ram and the assertion macro header.
//
//  channel | handshake              | payload
//  in      | in_valid_i / in_ready_o  | req_type_i, channel_i, force_value_i, speed_i
//  out     | out_valid_o / out_ready_i| actual_peak_o, target_peak_o
//
// Changed force sample: runs the 7-step restoring divider, then the scan of the percent RAM,
// one entry per cycle.
// Speed update: runs the scan only.
// Unchanged sample: no result; out-of-range channel: no result.
// Reset clears per-entry valid bits at once; entries not yet written read as zero.
// A result held by a stalled output lets the next item run until its own result is due.
module autoranging_force_percent_tracker #(
  parameter int CHANNELS_PER_GROUP = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                req_type_i,
  input  logic [aftrk_pkg::ChanW-1:0]         channel_i,
  input  logic signed [aftrk_pkg::SampleW-1:0] force_value_i,
  input  logic [aftrk_pkg::SpeedW-1:0]        speed_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [aftrk_pkg::PctW-1:0]   actual_peak_o,
  output logic signed [aftrk_pkg::PctW-1:0]   target_peak_o
);

  `include "autoranging_force_percent_tracker_assert.svh"

  localparam int NumCh = 2 * CHANNELS_PER_GROUP;
  localparam int AddrW = $clog2(NumCh);
  localparam int CntW  = $clog2(NumCh + 1);
  localparam int SW    = aftrk_pkg::SampleW;
  localparam int PW    = aftrk_pkg::PctW;
  localparam int QW    = aftrk_pkg::QuoW;
  localparam int NW    = aftrk_pkg::NumW;
  localparam int MainW = 3 * SW;

  function automatic logic [QW-1:0] pct_mag(input logic signed [PW-1:0] v);
    logic [PW-1:0] n;
    n = v[PW-1] ? PW'(-v) : v;
    return n[QW-1:0];
  endfunction

  aftrk_pkg::state_e state_q, state_d;

  logic [AddrW-1:0]           ch_q;
  logic signed [SW-1:0]       smp_q;
  logic [aftrk_pkg::SpeedW-1:0] speed_q;
  logic [SW-1:0]              den_q, absp_q;
  logic                       neg_q;
  logic [NW-1:0]              rem_q;
  logic [QW-1:0]              quo_q;
  logic [aftrk_pkg::BitW-1:0] bit_q;
  logic [CntW-1:0]            cnt_q;
  logic signed [PW-1:0]       act_best_q, tgt_best_q;
  logic signed [PW-1:0]       act_q, tgt_q;
  logic                       out_valid_q;

  logic [NumCh-1:0] main_vld_q, pct_vld_q;
  logic             main_rv_q, pct_rv_q;

  logic             main_we;
  logic [AddrW-1:0] main_raddr;
  logic [MainW-1:0] main_wdata, main_rdata;
  logic             pct_we;
  logic [AddrW-1:0] pct_waddr, pct_raddr;
  logic [PW-1:0]    pct_wdata, pct_rdata;

  logic [SW-1:0]        chan_ext;
  logic                 chan_ok;
  logic signed [SW-1:0] old_min, old_max, old_last, new_min, new_max;
  logic                 changed;
  logic [SW:0]          min_neg, p_neg;
  logic [NW-1:0]        shifted;
  logic [PW-1:0]        quo_signed;
  logic [AddrW-1:0]     scan_idx;
  logic signed [PW-1:0] scan_v;
  logic                 scan_clr, out_load;

  aftrk_ram #(.Width(MainW), .Depth(NumCh)) u_main_ram (
    .clk_i   (clk_i),
    .we_i    (main_we),
    .waddr_i (ch_q),
    .wdata_i (main_wdata),
    .raddr_i (main_raddr),
    .rdata_o (main_rdata)
  );

  aftrk_ram #(.Width(PW), .Depth(NumCh)) u_pct_ram (
    .clk_i   (clk_i),
    .we_i    (pct_we),
    .waddr_i (pct_waddr),
    .wdata_i (pct_wdata),
    .raddr_i (pct_raddr),
    .rdata_o (pct_rdata)
  );

  assign chan_ext   = SW'(channel_i);
  assign chan_ok    = chan_ext < SW'(NumCh);
  assign main_raddr = chan_ext[AddrW-1:0];
  assign in_ready_o = (state_q == aftrk_pkg::ST_IDLE);

  // read-modify-write of extremes and last sample
  always_comb begin
    old_min  = main_rv_q ? main_rdata[SW-1:0]      : '0;
    old_max  = main_rv_q ? main_rdata[2*SW-1:SW]   : '0;
    old_last = main_rv_q ? main_rdata[3*SW-1:2*SW] : '0;
    new_min  = (smp_q < old_min) ? smp_q : old_min;
    new_max  = (smp_q > old_max) ? smp_q : old_max;
    changed  = (old_last != smp_q);
    if (changed && !smp_q[SW-1] && new_max == '0) begin
      new_max = SW'(1);
    end
    main_wdata = {changed ? smp_q : old_last, new_max, new_min};
    min_neg    = -{new_min[SW-1], new_min};
    p_neg      = -{smp_q[SW-1], smp_q};
  end

  assign shifted    = NW'(den_q) << bit_q;
  assign quo_signed = neg_q ? PW'(-{1'b0, quo_q}) : {1'b0, quo_q};
  assign scan_idx   = AddrW'(cnt_q - CntW'(1));
  assign pct_raddr  = cnt_q[AddrW-1:0];

  always_comb begin
    scan_v   = pct_rv_q ? pct_rdata : '0;
    scan_clr = 1'b0;
    if (speed_q == '0 && scan_v[PW-1]) begin
      scan_clr = 1'b1;
      scan_v   = '0;
    end
  end

  always_comb begin
    state_d   = state_q;
    main_we   = 1'b0;
    pct_we    = 1'b0;
    pct_waddr = ch_q;
    pct_wdata = quo_signed;
    out_load  = 1'b0;
    unique case (state_q)
      aftrk_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (req_type_i) begin
            state_d = aftrk_pkg::ST_SCAN;
          end else if (chan_ok) begin
            state_d = aftrk_pkg::ST_CALC;
          end
        end
      end
      aftrk_pkg::ST_CALC: begin
        main_we = 1'b1;
        state_d = changed ? aftrk_pkg::ST_MUL : aftrk_pkg::ST_IDLE;
      end
      aftrk_pkg::ST_MUL: begin
        state_d = aftrk_pkg::ST_DIV;
      end
      aftrk_pkg::ST_DIV: begin
        if (bit_q == '0) begin
          state_d = aftrk_pkg::ST_PWR;
        end
      end
      aftrk_pkg::ST_PWR: begin
        pct_we  = 1'b1;
        state_d = aftrk_pkg::ST_SCAN;
      end
      aftrk_pkg::ST_SCAN: begin
        if (cnt_q != '0 && scan_clr) begin
          pct_we    = 1'b1;
          pct_waddr = scan_idx;
          pct_wdata = '0;
        end
        if (cnt_q == CntW'(NumCh)) begin
          state_d = aftrk_pkg::ST_DONE;
        end
      end
      aftrk_pkg::ST_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_load = 1'b1;
          state_d  = aftrk_pkg::ST_IDLE;
        end
      end
      default: state_d = aftrk_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= aftrk_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      main_vld_q  <= '0;
      pct_vld_q   <= '0;
      main_rv_q   <= 1'b0;
      pct_rv_q    <= 1'b0;
      speed_q     <= '0;
      cnt_q       <= '0;
    end else begin
      state_q   <= state_d;
      main_rv_q <= main_vld_q[main_raddr];
      pct_rv_q  <= pct_vld_q[pct_raddr];
      if (main_we) begin
        main_vld_q[ch_q] <= 1'b1;
      end
      if (pct_we) begin
        pct_vld_q[pct_waddr] <= 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_valid_i && in_ready_o && req_type_i) begin
        speed_q <= speed_i;
      end
      if (state_q == aftrk_pkg::ST_SCAN) begin
        cnt_q <= cnt_q + CntW'(1);
      end else begin
        cnt_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      ch_q  <= main_raddr;
      smp_q <= force_value_i;
    end
    if (state_q == aftrk_pkg::ST_IDLE || state_q == aftrk_pkg::ST_PWR) begin
      act_best_q <= '0;
      tgt_best_q <= '0;
    end
    unique case (state_q)
      aftrk_pkg::ST_CALC: begin
        neg_q  <= smp_q[SW-1];
        absp_q <= smp_q[SW-1] ? p_neg[SW-1:0] : smp_q;
        den_q  <= smp_q[SW-1] ? min_neg[SW-1:0] : new_max;
      end
      aftrk_pkg::ST_MUL: begin
        rem_q <= NW'(absp_q) * NW'(aftrk_pkg::PctScale);
        quo_q <= '0;
        bit_q <= aftrk_pkg::BitW'(QW - 1);
      end
      aftrk_pkg::ST_DIV: begin
        if (rem_q >= shifted) begin
          rem_q        <= rem_q - shifted;
          quo_q[bit_q] <= 1'b1;
        end
        bit_q <= bit_q - aftrk_pkg::BitW'(1);
      end
      aftrk_pkg::ST_SCAN: begin
        if (cnt_q != '0) begin
          if (scan_idx < AddrW'(CHANNELS_PER_GROUP)) begin
            if (pct_mag(scan_v) > pct_mag(act_best_q)) begin
              act_best_q <= scan_v;
            end
          end else if (pct_mag(scan_v) > pct_mag(tgt_best_q)) begin
            tgt_best_q <= scan_v;
          end
        end
      end
      aftrk_pkg::ST_DONE: begin
        if (out_load) begin
          act_q <= act_best_q;
          tgt_q <= tgt_best_q;
        end
      end
      default: ;
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign actual_peak_o = act_q;
  assign target_peak_o = tgt_q;

  `AFTRK_ASSERT_IMP(a_den_nonzero, state_q == aftrk_pkg::ST_MUL, den_q != '0,
                    "divisor is zero")
  `AFTRK_ASSERT_IMP(a_quo_range, state_q == aftrk_pkg::ST_PWR, quo_q <= QW'(100),
                    "percent out of range")
  `AFTRK_ASSERT_IMP(a_scan_clear, state_q == aftrk_pkg::ST_SCAN && pct_we,
                    pct_wdata == '0 && speed_q == '0, "scan wrote a nonzero percent")
  `AFTRK_ASSERT_NXT(a_load, state_q == aftrk_pkg::ST_DONE && !out_valid_q,
                    out_valid_q && state_q == aftrk_pkg::ST_IDLE, "result not loaded")

endmodule
